### rtl/kla_pkg.sv
// ----------------------------------------------------------------------------
// kla_pkg
// Shared types and codes of the keyed lowest free id allocator: command and
// status codes, sequencer states and the control word of a ring cell.
// ----------------------------------------------------------------------------
`default_nettype none

package kla_pkg;

   // command codes carried by a request word
   localparam logic [1:0] CMD_OBTAIN = 2'd0;
   localparam logic [1:0] CMD_BIND   = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   // status codes carried by a response word
   localparam logic [2:0] ST_FOUND   = 3'd0;
   localparam logic [2:0] ST_ALLOC   = 3'd1;
   localparam logic [2:0] ST_BOUND   = 3'd2;
   localparam logic [2:0] ST_DELETED = 3'd3;
   localparam logic [2:0] ST_ABSENT  = 3'd4;
   localparam logic [2:0] ST_NOFREE  = 3'd5;
   localparam logic [2:0] ST_REJECT  = 3'd6;

   // sequencer states
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_COMMIT
   } state_type;

   // per-cell control: rotate one place, write, clear
   typedef struct packed {
      logic shift;
      logic load;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### rtl/keyed_lowest_free_id_allocator_core.sv
// ----------------------------------------------------------------------------
// keyed_lowest_free_id_allocator_core
// Owner key to slot id table with a free id bitmap, both held in rings of
// cells that rotate one place per cycle during a scan past a single inspection head.
// Flow: an accepted request word runs a scan while the rings make one full turn
//   through the head comparator, then a commit; the response word is registered
//   from the commit state. busy stays high through scan and commit, so no new
//   request word is taken before the last one is through.
// Reset: all entries invalid, all ids free, binding count zero.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_lowest_free_id_allocator_core #(
   parameter int IMAGES          = 4,
   parameter int SLOTS_PER_IMAGE = 64,
   parameter int TABLE_ENTRIES   = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_owner_key,
   input  wire logic [31:0] req_given_id,
   output logic             rsp_valid,
   output logic [7:0]       rsp_slot_id,
   output logic [1:0]       rsp_image_index,
   output logic [5:0]       rsp_slot_in_image,
   output logic [2:0]       rsp_status,
   output logic [8:0]       rsp_binding_count
);

   localparam int IDS      = IMAGES * SLOTS_PER_IMAGE;
   localparam int SCAN_LEN = (TABLE_ENTRIES > IDS) ? TABLE_ENTRIES : IDS;
   localparam int ID_W     = (IDS > 1) ? $clog2(IDS) : 1;
   localparam int EIDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int IMG_W    = (IMAGES > 1) ? $clog2(IMAGES) : 1;
   localparam int SII_W    = (SLOTS_PER_IMAGE > 1) ? $clog2(SLOTS_PER_IMAGE) : 1;
   localparam int K_W      = $clog2(SCAN_LEN + 1);
   localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);

   // sequencer
   kla_pkg::state_type state_ff;
   kla_pkg::state_type state_in;
   logic               accept;
   logic               scan_active;
   logic               commit_active;
   logic [K_W-1:0]     k_ff;
   logic [K_W-1:0]     k_in;
   logic               k_last;

   // request word
   logic [1:0]        cmd_ff;
   logic [31:0]       key_ff;
   logic [ID_W-1:0]   gid_ff;
   logic              gid_ok_ff;

   // id split counters running with the free ring
   logic [IMG_W-1:0]  img_cnt_ff;
   logic [SII_W-1:0]  sii_cnt_ff;

   // scan findings
   logic              found_ff;
   logic [EIDX_W-1:0] found_idx_ff;
   logic [ID_W-1:0]   found_id_ff;
   logic [IMG_W-1:0]  found_img_ff;
   logic [SII_W-1:0]  found_sii_ff;
   logic              empty_ff;
   logic [EIDX_W-1:0] empty_idx_ff;
   logic              free_found_ff;
   logic [ID_W-1:0]   free_id_ff;
   logic [IMG_W-1:0]  free_img_ff;
   logic [SII_W-1:0]  free_sii_ff;
   logic [IMG_W-1:0]  gid_img_ff;
   logic [SII_W-1:0]  gid_sii_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   // ring head view and shift enables
   logic              ent_shift;
   logic              free_shift;
   logic              head_match;
   logic              head_empty;
   logic              head_free;
   logic              head_gid;

   // commit decisions
   logic              ent_load;
   logic              ent_clear;
   logic [EIDX_W-1:0] ent_idx;
   logic [ID_W-1:0]   wr_id;
   logic [IMG_W-1:0]  wr_img;
   logic [SII_W-1:0]  wr_sii;
   logic              take_en;
   logic [ID_W-1:0]   take_idx;
   logic              release_en;
   logic [ID_W-1:0]   release_idx;
   logic              res_ok;
   logic [2:0]        res_status;
   logic [ID_W-1:0]   res_id;
   logic [IMG_W-1:0]  res_img;
   logic [SII_W-1:0]  res_sii;
   logic [31:0]       res_id_ext;
   logic [31:0]       res_img_ext;
   logic [31:0]       res_sii_ext;
   logic [31:0]       count_ext;

   // response registers
   logic              rsp_valid_ff;
   logic [7:0]        slot_id_ff;
   logic [1:0]        image_index_ff;
   logic [5:0]        slot_in_image_ff;
   logic [2:0]        status_ff;
   logic [8:0]        binding_count_ff;

   // cell outputs
   logic              cell_valid [TABLE_ENTRIES];
   logic [31:0]       cell_key   [TABLE_ENTRIES];
   logic [ID_W-1:0]   cell_id    [TABLE_ENTRIES];
   logic [IMG_W-1:0]  cell_img   [TABLE_ENTRIES];
   logic [SII_W-1:0]  cell_sii   [TABLE_ENTRIES];
   logic              cell_free  [IDS];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kla_pkg::STATE_IDLE: begin
            if (start) begin
               state_in = kla_pkg::STATE_SCAN;
            end
         end
         kla_pkg::STATE_SCAN: begin
            if (k_last) begin
               state_in = kla_pkg::STATE_COMMIT;
            end
         end
         kla_pkg::STATE_COMMIT: begin
            state_in = kla_pkg::STATE_IDLE;
         end
         default: begin
            state_in = kla_pkg::STATE_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy          = 1'b1;
      scan_active   = 1'b0;
      commit_active = 1'b0;
      unique case (state_ff)
         kla_pkg::STATE_IDLE:   busy          = 1'b0;
         kla_pkg::STATE_SCAN:   scan_active   = 1'b1;
         kla_pkg::STATE_COMMIT: commit_active = 1'b1;
         default:               busy          = 1'b1;
      endcase
   end

   assign accept = start & ~busy;
   assign k_last = (k_ff == K_W'(SCAN_LEN - 1));
   assign k_in   = accept ? '0 : (scan_active ? k_ff + K_W'(1) : k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kla_pkg::STATE_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         key_ff    <= req_owner_key;
         gid_ff    <= req_given_id[ID_W-1:0];
         gid_ok_ff <= (req_given_id < 32'(IDS));
      end
   end

   // head inspection: cell 0 holds original entry k while the ring turns
   assign ent_shift  = scan_active && (k_ff < K_W'(TABLE_ENTRIES));
   assign free_shift = scan_active && (k_ff < K_W'(IDS));
   assign head_match = ent_shift && cell_valid[0] && (cell_key[0] == key_ff);
   assign head_empty = ent_shift && !cell_valid[0];
   assign head_free  = free_shift && cell_free[0];
   assign head_gid   = free_shift && gid_ok_ff && (k_ff[ID_W-1:0] == gid_ff);

   // lowest-index findings, first hit wins
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         empty_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (accept) begin
         found_ff      <= 1'b0;
         empty_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (head_match && !found_ff) begin
            found_ff <= 1'b1;
         end
         if (head_empty && !empty_ff) begin
            empty_ff <= 1'b1;
         end
         if (head_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_match && !found_ff) begin
         found_idx_ff <= k_ff[EIDX_W-1:0];
         found_id_ff  <= cell_id[0];
         found_img_ff <= cell_img[0];
         found_sii_ff <= cell_sii[0];
      end
      if (head_empty && !empty_ff) begin
         empty_idx_ff <= k_ff[EIDX_W-1:0];
      end
      if (head_free && !free_found_ff) begin
         free_id_ff  <= k_ff[ID_W-1:0];
         free_img_ff <= img_cnt_ff;
         free_sii_ff <= sii_cnt_ff;
      end
      if (head_gid) begin
         gid_img_ff <= img_cnt_ff;
         gid_sii_ff <= sii_cnt_ff;
      end
   end

   // image / slot counters track the id at the free ring head
   always_ff @(posedge clock) begin
      if (reset || accept) begin
         img_cnt_ff <= '0;
         sii_cnt_ff <= '0;
      end else if (free_shift) begin
         if (sii_cnt_ff == SII_W'(SLOTS_PER_IMAGE - 1)) begin
            sii_cnt_ff <= '0;
            img_cnt_ff <= img_cnt_ff + IMG_W'(1);
         end else begin
            sii_cnt_ff <= sii_cnt_ff + SII_W'(1);
         end
      end
   end

   // commit decision per command
   always_comb begin
      ent_load    = 1'b0;
      ent_clear   = 1'b0;
      ent_idx     = empty_idx_ff;
      wr_id       = free_id_ff;
      wr_img      = free_img_ff;
      wr_sii      = free_sii_ff;
      take_en     = 1'b0;
      take_idx    = free_id_ff;
      release_en  = 1'b0;
      release_idx = found_id_ff;
      res_ok      = 1'b0;
      res_status  = kla_pkg::ST_REJECT;
      res_id      = found_id_ff;
      res_img     = found_img_ff;
      res_sii     = found_sii_ff;
      count_in    = count_ff;
      unique case (cmd_ff)
         kla_pkg::CMD_OBTAIN: begin
            priority if (found_ff) begin
               res_ok     = 1'b1;
               res_status = kla_pkg::ST_FOUND;
            end else if (!free_found_ff) begin
               res_status = kla_pkg::ST_NOFREE;
            end else if (empty_ff) begin
               res_ok     = 1'b1;
               res_status = kla_pkg::ST_ALLOC;
               res_id     = free_id_ff;
               res_img    = free_img_ff;
               res_sii    = free_sii_ff;
               ent_load   = 1'b1;
               take_en    = 1'b1;
               count_in   = count_ff + CNT_W'(1);
            end else begin
               res_status = kla_pkg::ST_REJECT;
            end
         end
         kla_pkg::CMD_BIND: begin
            wr_id    = gid_ff;
            wr_img   = gid_img_ff;
            wr_sii   = gid_sii_ff;
            take_idx = gid_ff;
            res_id   = gid_ff;
            res_img  = gid_img_ff;
            res_sii  = gid_sii_ff;
            priority if (!gid_ok_ff) begin
               res_status = kla_pkg::ST_REJECT;
            end else if (found_ff) begin
               res_ok     = 1'b1;
               res_status = kla_pkg::ST_BOUND;
               take_en    = 1'b1;
            end else if (empty_ff) begin
               res_ok     = 1'b1;
               res_status = kla_pkg::ST_BOUND;
               ent_load   = 1'b1;
               take_en    = 1'b1;
               count_in   = count_ff + CNT_W'(1);
            end else begin
               res_status = kla_pkg::ST_REJECT;
            end
         end
         kla_pkg::CMD_DELETE: begin
            ent_idx = found_idx_ff;
            if (found_ff) begin
               res_ok     = 1'b1;
               res_status = kla_pkg::ST_DELETED;
               ent_clear  = 1'b1;
               release_en = 1'b1;
               count_in   = count_ff - CNT_W'(1);
            end else begin
               res_status = kla_pkg::ST_ABSENT;
            end
         end
         default: begin
            res_status = kla_pkg::ST_REJECT;
         end
      endcase
   end

   assign res_id_ext  = res_ok ? 32'(res_id)  : '0;
   assign res_img_ext = res_ok ? 32'(res_img) : '0;
   assign res_sii_ext = res_ok ? 32'(res_sii) : '0;
   assign count_ext   = 32'(count_in);

   // binding count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (commit_active) begin
         count_ff <= count_in;
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= commit_active;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_active) begin
         slot_id_ff       <= res_id_ext[7:0];
         image_index_ff   <= res_img_ext[1:0];
         slot_in_image_ff <= res_sii_ext[5:0];
         status_ff        <= res_status;
         binding_count_ff <= count_ext[8:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_id       = slot_id_ff;
   assign rsp_image_index   = image_index_ff;
   assign rsp_slot_in_image = slot_in_image_ff;
   assign rsp_status        = status_ff;
   assign rsp_binding_count = binding_count_ff;

   // key table ring: cell i takes from cell i+1, the last from cell 0
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
      localparam int NXT = (i + 1) % TABLE_ENTRIES;
      kla_pkg::cell_ctrl_type ectrl;

      assign ectrl.shift = ent_shift;
      assign ectrl.load  = commit_active && ent_load  && (ent_idx == EIDX_W'(i));
      assign ectrl.clear = commit_active && ent_clear && (ent_idx == EIDX_W'(i));

      kla_entry_cell #(
         .ID_W  (ID_W),
         .IMG_W (IMG_W),
         .SII_W (SII_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ectrl),
         .nxt_valid  (cell_valid[NXT]),
         .nxt_key    (cell_key[NXT]),
         .nxt_id     (cell_id[NXT]),
         .nxt_img    (cell_img[NXT]),
         .nxt_sii    (cell_sii[NXT]),
         .wr_key     (key_ff),
         .wr_id      (wr_id),
         .wr_img     (wr_img),
         .wr_sii     (wr_sii),
         .cell_valid (cell_valid[i]),
         .cell_key   (cell_key[i]),
         .cell_id    (cell_id[i]),
         .cell_img   (cell_img[i]),
         .cell_sii   (cell_sii[i])
      );
   end

   // free id ring
   for (genvar j = 0; j < IDS; j++) begin : g_free
      localparam int NXT = (j + 1) % IDS;
      kla_pkg::cell_ctrl_type fctrl;

      assign fctrl.shift = free_shift;
      assign fctrl.load  = commit_active && take_en && (take_idx == ID_W'(j));
      assign fctrl.clear = commit_active && release_en && (release_idx == ID_W'(j));

      kla_free_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (fctrl),
         .nxt_free  (cell_free[NXT]),
         .cell_free (cell_free[j])
      );
   end

   // checks
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == kla_pkg::STATE_COMMIT)
      else $error("response strobe without a commit cycle");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == kla_pkg::STATE_SCAN) && (k_ff == '0))
      else $error("accepted request did not start a scan");

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      (scan_active && !k_last) |=> scan_active && (k_ff == $past(k_ff) + K_W'(1)))
      else $error("scan counter skipped");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("binding count above table size");

   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == kla_pkg::ST_ABSENT || status_ff == kla_pkg::ST_NOFREE
       || status_ff == kla_pkg::ST_REJECT)) |-> (slot_id_ff == '0) && (image_index_ff == '0))
      else $error("failed response carries an id");

endmodule

`default_nettype wire

### rtl/kla_entry_cell.sv
// ----------------------------------------------------------------------------
// kla_entry_cell
// One binding of the key table ring: valid flag, owner key, slot id and its
// image / slot split. Rotates toward the head, takes a write or is cleared in place.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_entry_cell #(
   parameter int ID_W  = 8,
   parameter int IMG_W = 2,
   parameter int SII_W = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kla_pkg::cell_ctrl_type ctrl,
   input  wire logic                  nxt_valid,
   input  wire logic [31:0]           nxt_key,
   input  wire logic [ID_W-1:0]       nxt_id,
   input  wire logic [IMG_W-1:0]      nxt_img,
   input  wire logic [SII_W-1:0]      nxt_sii,
   input  wire logic [31:0]           wr_key,
   input  wire logic [ID_W-1:0]       wr_id,
   input  wire logic [IMG_W-1:0]      wr_img,
   input  wire logic [SII_W-1:0]      wr_sii,
   output logic                       cell_valid,
   output logic [31:0]                cell_key,
   output logic [ID_W-1:0]            cell_id,
   output logic [IMG_W-1:0]           cell_img,
   output logic [SII_W-1:0]           cell_sii
);

   logic             valid_ff;
   logic             valid_in;
   logic [31:0]      key_ff;
   logic [ID_W-1:0]  id_ff;
   logic [IMG_W-1:0] img_ff;
   logic [SII_W-1:0] sii_ff;

   // valid flag: rotate, set on write, drop on clear
   always_comb begin
      priority if (ctrl.shift) begin
         valid_in = nxt_valid;
      end else if (ctrl.load) begin
         valid_in = 1'b1;
      end else if (ctrl.clear) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload rotates or takes the write word
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         key_ff <= nxt_key;
         id_ff  <= nxt_id;
         img_ff <= nxt_img;
         sii_ff <= nxt_sii;
      end else if (ctrl.load) begin
         key_ff <= wr_key;
         id_ff  <= wr_id;
         img_ff <= wr_img;
         sii_ff <= wr_sii;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_key   = key_ff;
   assign cell_id    = id_ff;
   assign cell_img   = img_ff;
   assign cell_sii   = sii_ff;

endmodule

`default_nettype wire

### rtl/kla_free_cell.sv
// ----------------------------------------------------------------------------
// kla_free_cell
// One bit of the free id ring. Rotates toward the head, or is marked taken
// (load) or free (clear) in place.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_free_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kla_pkg::cell_ctrl_type ctrl,
   input  wire logic                  nxt_free,
   output logic                       cell_free
);

   logic free_ff;
   logic free_in;

   // rotate, take or release
   always_comb begin
      priority if (ctrl.shift) begin
         free_in = nxt_free;
      end else if (ctrl.load) begin
         free_in = 1'b0;
      end else if (ctrl.clear) begin
         free_in = 1'b1;
      end else begin
         free_in = free_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b1;
      end else begin
         free_ff <= free_in;
      end
   end

   assign cell_free = free_ff;

endmodule

`default_nettype wire

### bench/keyed_lowest_free_id_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_lowest_free_id_allocator_core_tb
// Self-checking bench for the keyed id allocator. Request words are driven
// through the start/busy handshake, and a tracker class mirrors the key table
// and the free id map to predict every response word. Responses are compared
// in order. The run covers a directed opening, a mixed phase on a small key
// pool, a fill up to a full table and exhausted ids, and a drain back down.
// ----------------------------------------------------------------------------

module keyed_lowest_free_id_allocator_core_tb;

   localparam int IMAGES          = 4;
   localparam int SLOTS_PER_IMAGE = 64;
   localparam int TABLE_ENTRIES   = 256;
   localparam int TOTAL_IDS       = IMAGES * SLOTS_PER_IMAGE;
   localparam int SCAN_LEN        = (TABLE_ENTRIES > TOTAL_IDS) ? TABLE_ENTRIES : TOTAL_IDS;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int POOL_SIZE       = 16;

   // spare command code, no operation behind it
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] slot_id;
      logic [1:0] image_index;
      logic [5:0] slot_in_image;
      logic [2:0] status;
      logic [8:0] binding_count;
   } alloc_result_type;

   // mirror of the key table and free map, plus the queue of awaited responses
   class id_binding_tracker;
      bit          entry_used  [TABLE_ENTRIES];
      logic [31:0] entry_owner [TABLE_ENTRIES];
      int          entry_id    [TABLE_ENTRIES];
      bit          id_free     [TOTAL_IDS];
      int          bindings;
      alloc_result_type awaited_results[$];
      int          mismatches;
      int          checked;
      int          status_seen[8];

      function new();
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_used[i]  = 1'b0;
            entry_owner[i] = '0;
            entry_id[i]    = 0;
         end
         for (int i = 0; i < TOTAL_IDS; i++) id_free[i] = 1'b1;
         bindings   = 0;
         mismatches = 0;
         checked    = 0;
         for (int i = 0; i < 8; i++) status_seen[i] = 0;
      endfunction

      // lowest valid entry holding the key, -1 if none
      function int lookup(logic [31:0] key);
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (entry_used[i] && entry_owner[i] == key) return i;
         return -1;
      endfunction

      function int first_hole();
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!entry_used[i]) return i;
         return -1;
      endfunction

      function int lowest_free();
         for (int i = 0; i < TOTAL_IDS; i++)
            if (id_free[i]) return i;
         return -1;
      endfunction

      function void claim(int e, logic [31:0] key, int id);
         entry_used[e]  = 1'b1;
         entry_owner[e] = key;
         entry_id[e]    = id;
         bindings++;
      endfunction

      // key of some bound entry, or a fresh key when the table is empty
      function logic [31:0] pick_bound_key();
         int base;
         int e;
         base = $urandom_range(0, TABLE_ENTRIES - 1);
         for (int n = 0; n < TABLE_ENTRIES; n++) begin
            e = (base + n) % TABLE_ENTRIES;
            if (entry_used[e]) return entry_owner[e];
         end
         return $urandom;
      endfunction

      // apply an accepted request word and queue the response it must give
      function void note_request(logic [1:0] cmd, logic [31:0] key, logic [31:0] gid);
         int hit;
         int hole;
         int low;
         int id;
         bit ok;
         logic [2:0] st;
         alloc_result_type w;
         st  = kla_pkg::ST_REJECT;
         id  = 0;
         ok  = 1'b0;
         hit = lookup(key);
         case (cmd)
            kla_pkg::CMD_OBTAIN: begin
               if (hit >= 0) begin
                  id = entry_id[hit];
                  st = kla_pkg::ST_FOUND;
                  ok = 1'b1;
               end else begin
                  low = lowest_free();
                  if (low < 0) begin
                     st = kla_pkg::ST_NOFREE;
                  end else begin
                     hole = first_hole();
                     if (hole >= 0) begin
                        claim(hole, key, low);
                        id_free[low] = 1'b0;
                        id = low;
                        st = kla_pkg::ST_ALLOC;
                        ok = 1'b1;
                     end
                  end
               end
            end
            kla_pkg::CMD_BIND: begin
               // an already bound key keeps its entry, but the id is taken anyway
               if (gid < TOTAL_IDS) begin
                  hole = (hit >= 0) ? hit : first_hole();
                  if (hole >= 0) begin
                     if (hit < 0) claim(hole, key, int'(gid));
                     id_free[gid] = 1'b0;
                     id = int'(gid);
                     st = kla_pkg::ST_BOUND;
                     ok = 1'b1;
                  end
               end
            end
            kla_pkg::CMD_DELETE: begin
               if (hit < 0) begin
                  st = kla_pkg::ST_ABSENT;
               end else begin
                  // id read before the entry goes, freed even when shared
                  id = entry_id[hit];
                  entry_used[hit] = 1'b0;
                  if (bindings > 0) bindings--;
                  id_free[id] = 1'b1;
                  st = kla_pkg::ST_DELETED;
                  ok = 1'b1;
               end
            end
            default: ;
         endcase
         if (!ok) id = 0;
         w.slot_id       = id[7:0];
         w.image_index   = 2'(id / SLOTS_PER_IMAGE);
         w.slot_in_image = 6'(id % SLOTS_PER_IMAGE);
         w.status        = st;
         w.binding_count = 9'(bindings);
         status_seen[st]++;
         awaited_results.push_back(w);
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type want;
         checked++;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response word with nothing awaited:", $time,
                        " id=%0d img=%0d slot=%0d st=%0d count=%0d",
                        got.slot_id, got.image_index, got.slot_in_image,
                        got.status, got.binding_count);
            return;
         end
         want = awaited_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch expected id=%0d img=%0d slot=%0d st=%0d count=%0d,",
                        $time, want.slot_id, want.image_index, want.slot_in_image,
                        want.status, want.binding_count,
                        " got id=%0d img=%0d slot=%0d st=%0d count=%0d",
                        got.slot_id, got.image_index,
                        got.slot_in_image, got.status, got.binding_count);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [31:0] req_owner_key;
   logic [31:0] req_given_id;
   logic        rsp_valid;
   logic [7:0]  rsp_slot_id;
   logic [1:0]  rsp_image_index;
   logic [5:0]  rsp_slot_in_image;
   logic [2:0]  rsp_status;
   logic [8:0]  rsp_binding_count;

   id_binding_tracker tracker = new();
   int  words_sent  = 0;
   int  idle_cycles = 0;
   bit  steady_run  = 1'b0;
   logic [31:0] key_pool[POOL_SIZE];

   keyed_lowest_free_id_allocator_core #(
      .IMAGES          (IMAGES),
      .SLOTS_PER_IMAGE (SLOTS_PER_IMAGE),
      .TABLE_ENTRIES   (TABLE_ENTRIES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_owner_key     (req_owner_key),
      .req_given_id      (req_given_id),
      .rsp_valid         (rsp_valid),
      .rsp_slot_id       (rsp_slot_id),
      .rsp_image_index   (rsp_image_index),
      .rsp_slot_in_image (rsp_slot_in_image),
      .rsp_status        (rsp_status),
      .rsp_binding_count (rsp_binding_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_result({rsp_slot_id, rsp_image_index, rsp_slot_in_image,
                               rsp_status, rsp_binding_count});
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // mostly short gaps, a few long ones, with stretches of back-to-back words
   function int pick_gap();
      int r;
      if ($urandom_range(0, 31) == 0) steady_run = !steady_run;
      if (steady_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 3);
      if (r < 95) return $urandom_range(4, 40);
      return $urandom_range(100, 400);
   endfunction

   // entered and left just after a falling edge
   task automatic send_word(input logic [1:0] cmd, input logic [31:0] key,
                            input logic [31:0] gid);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         = 1'b1;
      req_cmd       = cmd;
      req_owner_key = key;
      req_given_id  = gid;
      do @(posedge clock); while (busy);
      tracker.note_request(cmd, key, gid);
      words_sent++;
      @(negedge clock);
   endtask

   // hold off the sender until every awaited response is back
   task automatic wait_drained();
      start = 1'b0;
      while (tracker.awaited_results.size() != 0) @(negedge clock);
   endtask

   function logic [31:0] any_id_in_range();
      return $urandom_range(0, TOTAL_IDS - 1);
   endfunction

   initial begin
      int r;
      logic [31:0] key;
      logic [31:0] gid;

      reset         = 1'b1;
      start         = 1'b0;
      req_cmd       = kla_pkg::CMD_OBTAIN;
      req_owner_key = '0;
      req_given_id  = '0;
      key_pool[0]   = 32'h0000_0000;
      key_pool[1]   = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening: extremes, shared ids, rejects and the spare command
      send_word(kla_pkg::CMD_OBTAIN, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(kla_pkg::CMD_OBTAIN, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(kla_pkg::CMD_OBTAIN, 32'h0000_0000, 32'h0000_0000);
      send_word(kla_pkg::CMD_BIND,   32'hA5A5_A5A5, TOTAL_IDS - 1);
      send_word(kla_pkg::CMD_BIND,   32'h5A5A_5A5A, TOTAL_IDS);
      send_word(kla_pkg::CMD_BIND,   32'h1234_5678, 32'hFFFF_FFFF);
      send_word(kla_pkg::CMD_BIND,   32'h0000_0000, 32'd7);
      send_word(kla_pkg::CMD_OBTAIN, 32'h0000_0000, 32'h8000_0000);
      send_word(kla_pkg::CMD_OBTAIN, 32'h1111_1111, 32'h0);
      send_word(kla_pkg::CMD_DELETE, 32'h0000_0000, 32'h0);
      send_word(kla_pkg::CMD_DELETE, 32'h0000_0000, 32'h0);
      send_word(kla_pkg::CMD_BIND,   32'hCAFE_0000, 32'd2);
      send_word(kla_pkg::CMD_DELETE, 32'h1111_1111, 32'h0);
      send_word(kla_pkg::CMD_OBTAIN, 32'h2222_2222, 32'h0);
      send_word(kla_pkg::CMD_OBTAIN, 32'h3333_3333, 32'h0);
      send_word(CMD_SPARE,           32'hDEAD_BEEF, 32'd1);
      send_word(kla_pkg::CMD_DELETE, 32'hCAFE_0000, 32'h0);
      send_word(kla_pkg::CMD_BIND,   32'hFFFF_FFFF, 32'd0);
      send_word(kla_pkg::CMD_OBTAIN, 32'h4444_4444, 32'h0);
      send_word(kla_pkg::CMD_DELETE, 32'hA5A5_A5A5, 32'h0);
      send_word(kla_pkg::CMD_BIND,   32'h7FFF_FFFF, 32'h8000_0000);
      send_word(kla_pkg::CMD_DELETE, 32'h9999_9999, 32'h0);
      wait_drained();

      // mixed traffic on a small key pool so keys keep hitting the table
      for (int n = 0; n < 150; n++) begin
         key = ($urandom_range(0, 9) == 0) ? $urandom
             : key_pool[$urandom_range(0, POOL_SIZE - 1)];
         r = $urandom_range(0, 9);
         gid = (r < 8) ? any_id_in_range()
             : (r == 8) ? 32'($urandom_range(TOTAL_IDS, TOTAL_IDS + 15)) : $urandom;
         r = $urandom_range(0, 99);
         if (r < 40)      send_word(kla_pkg::CMD_OBTAIN, key, $urandom);
         else if (r < 70) send_word(kla_pkg::CMD_BIND, key, gid);
         else if (r < 95) send_word(kla_pkg::CMD_DELETE, key, $urandom);
         else             send_word(CMD_SPARE, key, $urandom);
      end

      // fill until the table is full or the ids run out
      for (int n = 0; n < 320; n++) begin
         if (tracker.bindings == TABLE_ENTRIES || tracker.lowest_free() < 0) break;
         r = $urandom_range(0, 99);
         if (r < 85)
            send_word(kla_pkg::CMD_OBTAIN, $urandom, $urandom);
         else if (r < 92)
            send_word(kla_pkg::CMD_OBTAIN, tracker.pick_bound_key(), $urandom);
         else if (r < 96)
            send_word(kla_pkg::CMD_BIND, tracker.pick_bound_key(), any_id_in_range());
         else
            send_word(kla_pkg::CMD_DELETE, tracker.pick_bound_key(), $urandom);
      end
      // top the table off with fresh keys on taken or free ids
      for (int n = 0; n < 40 && tracker.bindings < TABLE_ENTRIES; n++)
         send_word(kla_pkg::CMD_BIND, $urandom, any_id_in_range());

      // exhausted table: free one entry, refill it, then ask for new keys
      for (int n = 0; n < 10; n++) begin
         send_word(kla_pkg::CMD_DELETE, tracker.pick_bound_key(), $urandom);
         send_word(kla_pkg::CMD_BIND, $urandom, any_id_in_range());
         send_word(kla_pkg::CMD_OBTAIN, $urandom, $urandom);
         send_word(kla_pkg::CMD_OBTAIN, $urandom, $urandom);
      end
      wait_drained();

      // drain the table back down with some noise
      for (int n = 0; n < 160; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            send_word(kla_pkg::CMD_DELETE, tracker.pick_bound_key(), $urandom);
         else if (r < 65)
            send_word(kla_pkg::CMD_DELETE, $urandom, $urandom);
         else if (r < 85)
            send_word(kla_pkg::CMD_OBTAIN, $urandom, $urandom);
         else if (r < 95)
            send_word(kla_pkg::CMD_OBTAIN, tracker.pick_bound_key(), $urandom);
         else
            send_word(kla_pkg::CMD_BIND, $urandom, $urandom);
      end

      // let the last responses arrive, then watch for strays
      wait_drained();
      repeat (SCAN_LEN + 16) @(negedge clock);

      $display("sent %0d request words, checked %0d response words, %0d mismatches",
               words_sent, tracker.checked, tracker.mismatches);
      $display("statuses: found %0d alloc %0d bound %0d deleted %0d",
               tracker.status_seen[kla_pkg::ST_FOUND],
               tracker.status_seen[kla_pkg::ST_ALLOC],
               tracker.status_seen[kla_pkg::ST_BOUND],
               tracker.status_seen[kla_pkg::ST_DELETED],
               " absent %0d nofree %0d reject %0d",
               tracker.status_seen[kla_pkg::ST_ABSENT],
               tracker.status_seen[kla_pkg::ST_NOFREE],
               tracker.status_seen[kla_pkg::ST_REJECT]);
      if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### keyed_lowest_free_id_allocator_core.f
rtl/kla_pkg.sv
rtl/kla_entry_cell.sv
rtl/kla_free_cell.sv
rtl/keyed_lowest_free_id_allocator_core.sv
bench/keyed_lowest_free_id_allocator_core_tb.sv
